// ===== rtl/ipc_mailbox_doorbell_macros.svh =====
// assertion macros shared by the ipc mailbox rtl
`ifndef IPC_MAILBOX_DOORBELL_MACROS_SVH
`define IPC_MAILBOX_DOORBELL_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define IPCMB_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ipc mailbox check failed");

// next-cycle implication, sampled on clock, off while reset is high
`define IPCMB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ipc mailbox check failed");

`endif

// ===== rtl/ipcmb_pkg.sv =====
// package: types, codes and constants of the ipc mailbox
package ipcmb_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] IPC_FLAG   = 32'h4000_0000;
   localparam logic [31:0] PHYS_MASK  = 32'h7FFF_FFFF;
   localparam logic [31:0] MASK_RESET = IPC_FLAG;

   // control register bit positions
   localparam int CB_X1  = 0;
   localparam int CB_Y2  = 1;
   localparam int CB_Y1  = 2;
   localparam int CB_X2  = 3;
   localparam int CB_IY1 = 4;
   localparam int CB_IY2 = 5;
   localparam int CTRL_W = 6;

   typedef enum logic [2:0] {
      KIND_IPC_WRITE  = 3'd0,
      KIND_IPC_READ   = 3'd1,
      KIND_FLAG_CLEAR = 3'd2,
      KIND_MASK_WRITE = 3'd3,
      KIND_FLAGS_READ = 3'd4,
      KIND_MASK_READ  = 3'd5,
      KIND_REPLY_POST = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      REG_HOST_MSG   = 2'd0,
      REG_CONTROL    = 2'd1,
      REG_REPLY_ADDR = 2'd2,
      REG_UNUSED     = 2'd3
   } reg_sel_type;

   typedef enum logic {
      ST_EMPTY = 1'b0,
      ST_HOLD  = 1'b1
   } state_type;

   typedef struct packed {
      logic exec;
   } cmd_type;

endpackage

// ===== rtl/ipcmb_queue.sv =====
// circular address queue with head read-out and count
`include "ipc_mailbox_doorbell_macros.svh"

module ipcmb_queue
   import ipcmb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [31:0] push_data,
   input  logic        pop,
   output logic [31:0] head_data,
   output logic        empty,
   output logic        full
);

   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_W  = (PTR_W + 1)'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

   logic [31:0]      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok;
   logic [PTR_W:0]   wr_sum;
   logic [PTR_W:0]   wr_wrap;
   logic [PTR_W-1:0] wr_idx;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == DEPTH_C);
   assign push_ok   = push && !full;
   assign head_data = entry_ff[head_ff];

   // tail slot: head + count, folded back once
   assign wr_sum  = {1'b0, head_ff} + {1'b0, count_ff[PTR_W-1:0]};
   assign wr_wrap = (wr_sum >= DEPTH_W) ? (wr_sum - DEPTH_W) : wr_sum;
   assign wr_idx  = wr_wrap[PTR_W-1:0];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
      end
      if (push_ok && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_idx] <= push_data;
      end
   end

   `IPCMB_ASSERT_IMP(a_count_range, 1'b1, count_ff <= DEPTH_C)
   `IPCMB_ASSERT_IMP(a_pop_has_item, pop, !empty || push)
   `IPCMB_ASSERT_NEXT(a_full_holds, full && !pop, full)

endmodule

// ===== rtl/ipcmb_ctrl.sv =====
// controller: result register occupancy and beat acceptance
module ipcmb_ctrl
   import ipcmb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      rsp_valid = 1'b0;
      req_stall = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         ST_EMPTY: begin
            cmd.exec = req_valid;
            if (req_valid) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            rsp_valid = 1'b1;
            // result leaves this cycle unless rsp_stall: the next beat may take its place
            req_stall = rsp_stall;
            cmd.exec  = req_valid && !rsp_stall;
            if (!rsp_stall && !req_valid) begin
               state_in = ST_EMPTY;
            end
         end
         default: begin
            state_in = ST_EMPTY;
         end
      endcase
   end

endmodule

// ===== rtl/ipcmb_dp.sv =====
// datapath: mailbox registers, doorbell logic, queues and result register
`include "ipc_mailbox_doorbell_macros.svh"

module ipcmb_dp
   import ipcmb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [2:0]  kind,
   input  logic [1:0]  reg_index,
   input  logic [31:0] data,
   output logic [31:0] read_data,
   output logic        request_valid,
   output logic [31:0] request_addr,
   output logic        queue_overflow,
   output logic        irq_out
);

   logic [31:0]       host_msg_ff, reply_addr_ff, flags_ff, mask_ff;
   logic [CTRL_W-1:0] ctrl_ff;

   logic [31:0] rd_out_ff, addr_out_ff;
   logic        valid_out_ff, ovf_out_ff, irq_out_ff;

   kind_type          kind_sel;
   reg_sel_type       reg_sel;
   logic              ctrl_wr, flag_clr, rep_post, dispatch, doorbell, ready;
   logic              req_push, req_any, pop_req, pop_rep, raise;
   logic [CTRL_W-1:0] ctrl_wr_val, ctrl_a, ctrl_b;
   logic [31:0]       flags_a, flags_b, mask_b, rd_val, req_pop_data;
   logic [31:0]       req_head, rep_head;
   logic              req_empty, req_full, rep_empty, rep_full;

   assign kind_sel = kind_type'(kind);
   assign reg_sel  = reg_sel_type'(reg_index);
   assign ctrl_wr  = (kind_sel == KIND_IPC_WRITE) && (reg_sel == REG_CONTROL);
   assign flag_clr = (kind_sel == KIND_FLAG_CLEAR);
   assign rep_post = (kind_sel == KIND_REPLY_POST);
   assign dispatch = ctrl_wr || flag_clr;

   // control write: y bits are write-one-to-clear, the rest take the data
   always_comb begin
      ctrl_wr_val         = '0;
      ctrl_wr_val[CB_X1]  = data[CB_X1];
      ctrl_wr_val[CB_X2]  = data[CB_X2];
      ctrl_wr_val[CB_IY1] = data[CB_IY1];
      ctrl_wr_val[CB_IY2] = data[CB_IY2];
      ctrl_wr_val[CB_Y1]  = ctrl_ff[CB_Y1] && !data[CB_Y1];
      ctrl_wr_val[CB_Y2]  = ctrl_ff[CB_Y2] && !data[CB_Y2];
   end

   assign ctrl_a   = ctrl_wr ? ctrl_wr_val : ctrl_ff;
   assign doorbell = ctrl_wr && ((data[CB_Y1] && ctrl_wr_val[CB_IY1]) ||
                                 (data[CB_Y2] && ctrl_wr_val[CB_IY2]));

   always_comb begin
      flags_a = flags_ff;
      if (flag_clr) begin
         flags_a = flags_ff & ~data;
      end else if (doorbell) begin
         flags_a = flags_ff | IPC_FLAG;
      end
   end

   assign req_push = ctrl_wr && ctrl_wr_val[CB_X1];
   assign ready    = dispatch && !ctrl_a[CB_Y1] && !ctrl_a[CB_Y2] &&
                     ((flags_a & IPC_FLAG) == '0);
   // a queue that is empty is never full, so a push then always lands
   assign req_any  = !req_empty || req_push;
   assign pop_req  = ready && req_any;
   assign pop_rep  = ready && !req_any && !rep_empty;
   // pushed and popped in the same beat: the message goes straight through
   assign req_pop_data = req_empty ? host_msg_ff : req_head;

   always_comb begin
      ctrl_b = ctrl_a;
      if (pop_req) begin
         ctrl_b[CB_Y2] = 1'b1;
         ctrl_b[CB_X1] = 1'b0;
      end else if (pop_rep) begin
         ctrl_b[CB_Y1] = 1'b1;
      end
   end

   assign raise   = (pop_req || pop_rep) &&
                    ((ctrl_b[CB_Y1] && ctrl_b[CB_IY1]) ||
                     (ctrl_b[CB_Y2] && ctrl_b[CB_IY2]));
   assign flags_b = raise ? (flags_a | IPC_FLAG) : flags_a;
   assign mask_b  = (kind_sel == KIND_MASK_WRITE) ? data : mask_ff;

   always_comb begin
      rd_val = '0;
      case (kind_sel)
         KIND_IPC_READ: begin
            case (reg_sel)
               REG_HOST_MSG:   rd_val = host_msg_ff;
               REG_CONTROL:    rd_val = 32'(ctrl_ff);
               REG_REPLY_ADDR: rd_val = reply_addr_ff;
               REG_UNUSED:     rd_val = '0;
               default:        rd_val = '0;
            endcase
         end
         KIND_FLAGS_READ: rd_val = flags_ff;
         KIND_MASK_READ:  rd_val = mask_ff;
         default:         rd_val = '0;
      endcase
   end

   ipcmb_queue u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd.exec && req_push),
      .push_data (host_msg_ff),
      .pop       (cmd.exec && pop_req),
      .head_data (req_head),
      .empty     (req_empty),
      .full      (req_full)
   );

   ipcmb_queue u_rep_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd.exec && rep_post),
      .push_data (data),
      .pop       (cmd.exec && pop_rep),
      .head_data (rep_head),
      .empty     (rep_empty),
      .full      (rep_full)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         host_msg_ff   <= '0;
         reply_addr_ff <= '0;
         ctrl_ff       <= '0;
         flags_ff      <= '0;
         mask_ff       <= MASK_RESET;
      end else if (cmd.exec) begin
         if ((kind_sel == KIND_IPC_WRITE) && (reg_sel == REG_HOST_MSG)) begin
            host_msg_ff <= data;
         end
         if ((kind_sel == KIND_IPC_WRITE) && (reg_sel == REG_REPLY_ADDR)) begin
            reply_addr_ff <= data;
         end else if (pop_rep) begin
            reply_addr_ff <= rep_head & PHYS_MASK;
         end
         ctrl_ff  <= ctrl_b;
         flags_ff <= flags_b;
         mask_ff  <= mask_b;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rd_out_ff    <= rd_val;
         valid_out_ff <= pop_req;
         addr_out_ff  <= pop_req ? req_pop_data : '0;
         ovf_out_ff   <= (req_push && req_full) || (rep_post && rep_full);
         irq_out_ff   <= ((flags_b & mask_b) != '0);
      end
   end

   assign read_data      = rd_out_ff;
   assign request_valid  = valid_out_ff;
   assign request_addr   = addr_out_ff;
   assign queue_overflow = ovf_out_ff;
   assign irq_out        = irq_out_ff;

   `IPCMB_ASSERT_IMP(a_one_action, pop_req, !pop_rep)
   `IPCMB_ASSERT_NEXT(a_req_ack, cmd.exec && pop_req, ctrl_ff[CB_Y2] && !ctrl_ff[CB_X1])
   `IPCMB_ASSERT_NEXT(a_rep_load, cmd.exec && pop_rep, ctrl_ff[CB_Y1])

endmodule

// ===== rtl/ipc_mailbox_doorbell.sv =====
// top level: ipc mailbox with doorbell interrupt
//
// Mailbox between a host cpu and a service processor. Each req beat is one
// register access or event (ipc write/read, flag clear, mask write, flags
// read, mask read, reply post) and yields exactly one rsp beat. The whole
// beat, including the control-write doorbell, the request queue push and the
// single dispatch step, is combinational; its result lands in a result
// register and rsp_valid rises the cycle after acceptance. A new req beat is
// taken whenever the result register is empty or is being drained in the
// same cycle, so the block sustains one beat per clock; throughput drops
// only while rsp_stall holds the result register. The request and reply
// queues are 16-entry circular register files each; their contents are
// undefined until written, so there is no clearing pass after reset.
// A push to a full queue is dropped and reported on rsp_queue_overflow.
module ipc_mailbox_doorbell
   import ipcmb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [1:0]  req_reg_index,
   input  logic [31:0] req_data,

   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_request_valid,
   output logic [31:0] rsp_request_addr,
   output logic        rsp_queue_overflow,
   output logic        rsp_irq_out
);

   // exec: a req beat is accepted and applied this cycle
   cmd_type cmd;

   // controller owns the handshake and result register occupancy
   ipcmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath holds the mailbox state, queues and the result payload
   ipcmb_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .kind           (req_kind),
      .reg_index      (req_reg_index),
      .data           (req_data),
      .read_data      (rsp_read_data),
      .request_valid  (rsp_request_valid),
      .request_addr   (rsp_request_addr),
      .queue_overflow (rsp_queue_overflow),
      .irq_out        (rsp_irq_out)
   );

endmodule
